### hw/rtl/hcfr_pkg.sv
// Shared types, codes and the CRC-16 byte update for the host command frame receiver.
// No dependencies; every other file of the block imports this package.
package hcfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [WordW-1:0] CrcPoly = 16'h1021;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SYNC_PLAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_CRC   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CRC_SEED   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH = 2'd3;

  // byte_kind codes
  localparam logic [1:0] KIND_FRAMING = 2'd0;
  localparam logic [1:0] KIND_OPCODE  = 2'd1;
  localparam logic [1:0] KIND_PARAM   = 2'd2;

  // frame_status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] sync_plain;
    logic [ByteW-1:0] sync_crc;
    logic [WordW-1:0] crc_seed;
    logic [WordW-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [1:0]       byte_kind;
    logic             frame_done;
    logic [1:0]       frame_status;
    logic             frame_used_crc;
    logic [WordW-1:0] param_count;
    logic             tx_crc_mode;
  } res_t;

  // CRC-16 CCITT, MSB first, one byte per call
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc_in,
                                                input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[WordW-1]) begin
        c = {c[WordW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[WordW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/hcfr_if.sv
// Valid/ready channel interfaces for received bytes and per-byte results.
// Depends on hcfr_pkg for field widths.
interface hcfr_rx_if import hcfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface hcfr_res_if import hcfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [1:0]       byte_kind;
  logic             frame_done;
  logic [1:0]       frame_status;
  logic             frame_used_crc;
  logic [WordW-1:0] param_count;
  logic             tx_crc_mode;

  modport source(output valid, output data_byte, output byte_kind, output frame_done,
                 output frame_status, output frame_used_crc, output param_count,
                 output tx_crc_mode, input ready);
  modport sink(input valid, input data_byte, input byte_kind, input frame_done,
               input frame_status, input frame_used_crc, input param_count,
               input tx_crc_mode, output ready);
endinterface

### hw/rtl/hcfr_cfg_regs.sv
// Configuration register bank: sync bytes, CRC seed and length limit.
// Depends on hcfr_pkg.
module hcfr_cfg_regs import hcfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [CfgIdxW-1:0] index,
  input  logic [WordW-1:0]   data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_plain <= 8'hAA;
      cfg.sync_crc   <= 8'hAB;
      cfg.crc_seed   <= 16'hFFFF;
      cfg.max_length <= 16'd256;
    end else if (we) begin
      unique case (index)
        REG_SYNC_PLAIN: cfg.sync_plain <= data[ByteW-1:0];
        REG_SYNC_CRC:   cfg.sync_crc   <= data[ByteW-1:0];
        REG_CRC_SEED:   cfg.crc_seed   <= data;
        REG_MAX_LENGTH: cfg.max_length <= data;
      endcase
    end
  end

endmodule

### hw/rtl/hcfr_frame_fsm.sv
// Input byte register and frame parser: sync hunt, length, payload and check phases.
// Depends on hcfr_pkg (codes, cfg_t, res_t, crc_byte).
module hcfr_frame_fsm import hcfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_SUM    = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_t;

  phase_t           phase, phase_next;
  logic             crc_frame, crc_frame_next;
  logic [WordW-1:0] frame_length, frame_length_next;
  logic [WordW-1:0] bytes_seen, bytes_seen_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [WordW-1:0] running_crc, running_crc_next;
  logic             sticky, sticky_next;

  logic             byte_valid;
  logic [ByteW-1:0] b;
  logic             step;

  logic [ByteW-1:0] sum_abs;
  logic [WordW-1:0] crc_abs;
  logic [WordW-1:0] len_full;
  logic [WordW-1:0] seen_inc;
  logic [WordW-1:0] pcount;

  // Advance one byte whenever the result register can take it
  assign step      = byte_valid && res_ready;
  assign in_ready  = !byte_valid || step;
  assign res_valid = byte_valid;

  assign sum_abs  = running_sum + b;
  assign crc_abs  = crc_byte(running_crc, b);
  assign len_full = {frame_length[WordW-1:ByteW], b};
  assign seen_inc = bytes_seen + 16'd1;
  assign pcount   = frame_length - 16'd1;

  always_comb begin
    phase_next        = phase;
    crc_frame_next    = crc_frame;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    running_crc_next  = running_crc;
    sticky_next       = sticky;
    res.data_byte     = '0;
    res.byte_kind     = KIND_FRAMING;
    res.frame_done    = 1'b0;
    res.frame_status  = ST_GOOD;
    res.param_count   = '0;

    unique case (phase)
      PH_LEN_HI: begin
        frame_length_next = {b, 8'h00};
        running_sum_next  = sum_abs;
        running_crc_next  = crc_abs;
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = len_full;
        running_sum_next  = sum_abs;
        running_crc_next  = crc_abs;
        bytes_seen_next   = '0;
        if (len_full == '0 || len_full > cfg.max_length) begin
          res.frame_done   = 1'b1;
          res.frame_status = ST_BAD_LEN;
          phase_next       = PH_HUNT;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_next = sum_abs;
        running_crc_next = crc_abs;
        res.data_byte    = b;
        res.byte_kind    = (bytes_seen == '0) ? KIND_OPCODE : KIND_PARAM;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= frame_length) begin
          phase_next = crc_frame ? PH_CRC_HI : PH_SUM;
        end
      end
      PH_SUM: begin
        running_sum_next = sum_abs;
        running_crc_next = crc_abs;
        res.frame_done   = 1'b1;
        res.frame_status = (sum_abs == '0) ? ST_GOOD : ST_BAD_SUM;
        res.param_count  = pcount;
        phase_next       = PH_HUNT;
      end
      PH_CRC_HI: begin
        running_sum_next = sum_abs;
        running_crc_next = crc_abs;
        phase_next       = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        running_sum_next = sum_abs;
        running_crc_next = crc_abs;
        res.frame_done   = 1'b1;
        res.param_count  = pcount;
        if (crc_abs == '0) begin
          res.frame_status = ST_GOOD;
          sticky_next      = 1'b1;
        end else begin
          res.frame_status = ST_BAD_CRC;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        // Hunting, and any unused phase code
        phase_next = PH_HUNT;
        if (b == cfg.sync_crc || b == cfg.sync_plain) begin
          crc_frame_next    = (b == cfg.sync_crc);
          frame_length_next = '0;
          bytes_seen_next   = '0;
          running_sum_next  = '0;
          running_crc_next  = cfg.crc_seed;
          phase_next        = PH_LEN_HI;
        end else begin
          crc_frame_next = 1'b0;
        end
      end
    endcase

    res.frame_used_crc = crc_frame_next;
    res.tx_crc_mode    = sticky_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid   <= 1'b0;
      phase        <= PH_HUNT;
      crc_frame    <= 1'b0;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
      running_crc  <= '0;
      sticky       <= 1'b0;
    end else begin
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (step) begin
        phase        <= phase_next;
        crc_frame    <= crc_frame_next;
        frame_length <= frame_length_next;
        bytes_seen   <= bytes_seen_next;
        running_sum  <= running_sum_next;
        running_crc  <= running_crc_next;
        sticky       <= sticky_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      b <= in_byte;
    end
  end

endmodule

### hw/rtl/hcfr_out_stage.sv
// Result register between the frame parser and the result channel.
// Depends on hcfr_pkg (res_t).
module hcfr_out_stage import hcfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Hold the payload while the consumer stalls
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

### hw/rtl/host_command_frame_receiver_unit.sv
// Host command frame receiver: parses sync, length, payload and sum/CRC-16 check.
// Depends on hcfr_pkg, hcfr_if, hcfr_cfg_regs, hcfr_frame_fsm, hcfr_out_stage.
//
// Usage:
//   rx  : one received serial byte per transaction (valid/ready).
//   res : exactly one result per received byte, in order: the payload byte
//         tagged opcode or parameter, or a framing/check byte; the byte that
//         ends a frame carries frame_done, frame_status and param_count.
//   cfg_we/cfg_index/cfg_data : register writes (0 sync_plain, 1 sync_crc,
//         2 crc_seed, 3 max_length); write only while no byte is in flight.
// Path: an accepted byte is held in the input byte register, then in the result register.
// Throughput: one byte per clock while res.ready is high; the sum and one byte-wide CRC-16 update
//   sit in the single logic stage between the input byte register and the
//   result register.
// Reset: registers return to 0xAA/0xAB/0xFFFF/256, the parser hunts for
//   sync and the transmit-CRC flag clears.
// Stall: while res.ready is low the result holds, at most one more byte is
//   taken into the input register, then rx.ready drops until the result moves.
module host_command_frame_receiver_unit import hcfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  hcfr_rx_if.sink            rx,
  hcfr_res_if.source         res,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_data
);

  cfg_t cfg;
  res_t fsm_res;
  res_t out_res;
  logic fsm_valid;
  logic fsm_ready;

  hcfr_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  hcfr_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_byte   (rx.rx_byte),
    .res_valid (fsm_valid),
    .res_ready (fsm_ready),
    .res       (fsm_res)
  );

  hcfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fsm_valid),
    .in_ready  (fsm_ready),
    .in_res    (fsm_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.data_byte      = out_res.data_byte;
  assign res.byte_kind      = out_res.byte_kind;
  assign res.frame_done     = out_res.frame_done;
  assign res.frame_status   = out_res.frame_status;
  assign res.frame_used_crc = out_res.frame_used_crc;
  assign res.param_count    = out_res.param_count;
  assign res.tx_crc_mode    = out_res.tx_crc_mode;

`ifndef NO_ASSERTIONS
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.frame_done) |-> (res.frame_status == ST_GOOD && res.param_count == '0))
    else $error("status or parameter count set on a byte that does not end a frame");

  a_payload_not_end: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.byte_kind == KIND_OPCODE || res.byte_kind == KIND_PARAM))
      |-> !res.frame_done)
    else $error("payload byte marked as frame end");

  a_good_crc_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_done && res.frame_used_crc && res.frame_status == ST_GOOD)
      |-> res.tx_crc_mode)
    else $error("good CRC frame without transmit-CRC flag");

  a_sum_frame_status: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_done && !res.frame_used_crc) |-> (res.frame_status != ST_BAD_CRC))
    else $error("CRC error reported on a sum-checked frame");
`endif

endmodule

### tb/sv/host_command_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for host_command_frame_receiver_unit: directed, register and random
// frame traffic checked byte by byte against a local frame parser.
// Depends on hcfr_pkg, hcfr_if and the RTL of the block.
module host_command_frame_receiver_unit_tb import hcfr_pkg::*;;

  localparam int unsigned RunLimitNs = 2_000_000;
  localparam int unsigned ItemsPerSetting = 290;

  typedef enum logic [2:0] {
    P_HUNT, P_LEN_HIGH, P_LEN_LOW, P_PAYLOAD, P_SUM_BYTE, P_CRC_HIGH, P_CRC_LOW
  } parse_phase_t;

  typedef enum int {FLAW_NONE, FLAW_CHECK, FLAW_TRUNCATE} frame_flaw_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [WordW-1:0] cfg_data;

  hcfr_rx_if  rx_ch();
  hcfr_res_if res_ch();

  host_command_frame_receiver_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Parser shadow state and register copy
  cfg_t         shadow_cfg;
  parse_phase_t pr_phase;
  logic         pr_crc_frame;
  logic [15:0]  pr_len;
  logic [15:0]  pr_seen;
  logic [7:0]   pr_sum;
  logic [15:0]  pr_crc;
  logic         pr_sticky;

  res_t        pending_results[$];
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;

  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  logic [3:0]  stall_tick = '0;

  // Bit-serial CRC-16, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic void fold_byte(input logic [7:0] b);
    pr_sum = pr_sum + b;
    pr_crc = crc16_step(pr_crc, b);
  endfunction

  function automatic void reset_parser();
    shadow_cfg.sync_plain = 8'hAA;
    shadow_cfg.sync_crc   = 8'hAB;
    shadow_cfg.crc_seed   = 16'hFFFF;
    shadow_cfg.max_length = 16'd256;
    pr_phase     = P_HUNT;
    pr_crc_frame = 1'b0;
    pr_len       = '0;
    pr_seen      = '0;
    pr_sum       = '0;
    pr_crc       = '0;
    pr_sticky    = 1'b0;
  endfunction

  function automatic res_t predict_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    case (pr_phase)
      P_LEN_HIGH: begin
        pr_len = {b, 8'h00};
        fold_byte(b);
        pr_phase = P_LEN_LOW;
      end
      P_LEN_LOW: begin
        pr_len[7:0] = b;
        fold_byte(b);
        pr_seen = '0;
        if (pr_len == 16'd0 || pr_len > shadow_cfg.max_length) begin
          r.frame_done   = 1'b1;
          r.frame_status = ST_BAD_LEN;
          pr_phase = P_HUNT;
        end else begin
          pr_phase = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        fold_byte(b);
        r.data_byte = b;
        r.byte_kind = (pr_seen == 16'd0) ? KIND_OPCODE : KIND_PARAM;
        pr_seen = pr_seen + 16'd1;
        if (pr_seen >= pr_len) begin
          pr_phase = pr_crc_frame ? P_CRC_HIGH : P_SUM_BYTE;
        end
      end
      P_SUM_BYTE: begin
        fold_byte(b);
        r.frame_done   = 1'b1;
        r.frame_status = (pr_sum == 8'd0) ? ST_GOOD : ST_BAD_SUM;
        r.param_count  = pr_len - 16'd1;
        pr_phase = P_HUNT;
      end
      P_CRC_HIGH: begin
        fold_byte(b);
        pr_phase = P_CRC_LOW;
      end
      P_CRC_LOW: begin
        fold_byte(b);
        r.frame_done = 1'b1;
        if (pr_crc == 16'd0) begin
          r.frame_status = ST_GOOD;
          pr_sticky = 1'b1;
        end else begin
          r.frame_status = ST_BAD_CRC;
        end
        r.param_count = pr_len - 16'd1;
        pr_phase = P_HUNT;
      end
      default: begin
        pr_phase = P_HUNT;
        if (b == shadow_cfg.sync_crc || b == shadow_cfg.sync_plain) begin
          // equal sync registers resolve to a CRC frame
          pr_crc_frame = (b == shadow_cfg.sync_crc);
          pr_len   = '0;
          pr_seen  = '0;
          pr_sum   = '0;
          pr_crc   = shadow_cfg.crc_seed;
          pr_phase = P_LEN_HIGH;
        end else begin
          pr_crc_frame = 1'b0;
        end
      end
    endcase
    r.frame_used_crc = pr_crc_frame;
    r.tx_crc_mode    = pr_sticky;
    return r;
  endfunction

  // Receiver back-pressure: switch between randomly chosen ready pattern modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(64, 400);
    end else begin
      stall_left--;
    end
    stall_tick = stall_tick + 4'd1;
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      2: res_ch.ready <= (stall_tick[2:0] != 3'd5);
      default: res_ch.ready <= (stall_tick < 4'd10);
    endcase
  end

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.data_byte, res_ch.byte_kind, res_ch.frame_done, res_ch.frame_status,
             res_ch.frame_used_crc, res_ch.param_count, res_ch.tx_crc_mode};
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        compare_field("byte_kind", 16'(want.byte_kind), 16'(got.byte_kind));
        compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        compare_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
        compare_field("frame_used_crc", 16'(want.frame_used_crc), 16'(got.frame_used_crc));
        compare_field("param_count", want.param_count, got.param_count);
        compare_field("tx_crc_mode", 16'(want.tx_crc_mode), 16'(got.tx_crc_mode));
      end
    end
  end

  // One rx transaction, with bursts of random length and random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    pending_results.push_back(predict_byte(b));
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC_PLAIN: shadow_cfg.sync_plain = value[7:0];
      REG_SYNC_CRC:   shadow_cfg.sync_crc   = value[7:0];
      REG_CRC_SEED:   shadow_cfg.crc_seed   = value;
      default:        shadow_cfg.max_length = value;
    endcase
  endtask

  task automatic set_config(input logic [7:0] sp, input logic [7:0] sc,
                            input logic [15:0] seed, input logic [15:0] max_len);
    write_register(REG_SYNC_PLAIN, 16'(sp));
    write_register(REG_SYNC_CRC, 16'(sc));
    write_register(REG_CRC_SEED, seed);
    write_register(REG_MAX_LENGTH, max_len);
  endtask

  // Build a frame for the current registers and send it; bad lengths stop after the length
  task automatic send_frame(input bit want_crc, input logic [15:0] len, input frame_flaw_t flaw,
                            input bit fixed_fill, input logic [7:0] fill);
    logic [7:0]  frame_q[$];
    logic [7:0]  sum;
    logic [15:0] crc;
    logic [7:0]  b;
    bit          crc_kind;
    int unsigned keep;
    crc_kind = want_crc || (shadow_cfg.sync_plain == shadow_cfg.sync_crc);
    frame_q.push_back(crc_kind ? shadow_cfg.sync_crc : shadow_cfg.sync_plain);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    sum = len[15:8] + len[7:0];
    crc = crc16_step(crc16_step(shadow_cfg.crc_seed, len[15:8]), len[7:0]);
    if (len != 16'd0 && len <= shadow_cfg.max_length) begin
      for (int i = 0; i < int'(len); i++) begin
        b = fixed_fill ? fill : 8'($urandom);
        frame_q.push_back(b);
        sum = sum + b;
        crc = crc16_step(crc, b);
      end
      if (crc_kind) begin
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
      end else begin
        frame_q.push_back(8'h00 - sum);
      end
      if (flaw == FLAW_CHECK) begin
        frame_q[$] = frame_q[$] ^ 8'($urandom_range(1, 255));
      end
    end
    keep = frame_q.size();
    if (flaw == FLAW_TRUNCATE) begin
      keep = $urandom_range(1, frame_q.size() - 1);
    end
    for (int i = 0; i < int'(keep); i++) begin
      send_byte(frame_q[i]);
    end
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned cap;
    if (shadow_cfg.max_length == 16'd0) begin
      return 16'($urandom_range(1, 4));
    end
    cap = (shadow_cfg.max_length < 16'd10) ? shadow_cfg.max_length : 10;
    if ($urandom_range(0, 9) == 0) begin
      cap = (shadow_cfg.max_length < 16'd40) ? shadow_cfg.max_length : 40;
    end
    return 16'($urandom_range(1, cap));
  endfunction

  function automatic logic [15:0] pick_bad_length();
    if (shadow_cfg.max_length == 16'hFFFF || $urandom_range(0, 2) == 0) begin
      return 16'd0;
    end
    return 16'($urandom_range(int'(shadow_cfg.max_length) + 1, 65535));
  endfunction

  task automatic test_directed_frames();
    send_byte(8'h00);
    send_frame(1'b0, 16'd1, FLAW_NONE, 1'b1, 8'hFF);
    send_frame(1'b1, 16'd1, FLAW_NONE, 1'b1, 8'h00);
    send_frame(1'b0, 16'd0, FLAW_NONE, 1'b0, 8'h00);
    send_frame(1'b1, 16'hFFFF, FLAW_NONE, 1'b0, 8'h00);
    send_frame(1'b0, 16'd2, FLAW_CHECK, 1'b0, 8'h00);
    send_frame(1'b1, 16'd1, FLAW_CHECK, 1'b0, 8'h00);
  endtask

  task automatic test_register_extremes();
    set_config(8'h00, 8'hFF, 16'h0000, 16'd1);
    send_frame(1'b0, 16'd1, FLAW_NONE, 1'b1, 8'h00);
    send_frame(1'b1, 16'd1, FLAW_NONE, 1'b1, 8'hFF);
    send_frame(1'b0, 16'd2, FLAW_NONE, 1'b0, 8'h00);
    send_frame(1'b1, 16'd1, FLAW_CHECK, 1'b0, 8'h00);
    // equal sync bytes: every frame is a CRC frame
    set_config(8'h5A, 8'h5A, 16'hFFFF, 16'hFFFF);
    send_frame(1'b0, 16'd3, FLAW_NONE, 1'b0, 8'h00);
    send_frame(1'b1, 16'd2, FLAW_CHECK, 1'b0, 8'h00);
    send_frame(1'b0, 16'd300, FLAW_NONE, 1'b0, 8'h00);
    // zero max length rejects every length
    set_config(8'hAA, 8'hAB, 16'h1D0F, 16'd0);
    send_frame(1'b0, 16'd1, FLAW_NONE, 1'b0, 8'h00);
    send_frame(1'b1, 16'd5, FLAW_NONE, 1'b0, 8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  same_sync;
    for (int k = 0; k < 5; k++) begin
      same_sync = 8'($urandom);
      case (k)
        0: set_config(8'hAA, 8'hAB, 16'hFFFF, 16'd256);
        1: set_config(8'hFF, 8'h00, 16'($urandom), 16'($urandom_range(1, 24)));
        2: set_config(same_sync, same_sync, 16'($urandom), 16'hFFFF);
        default: set_config(8'($urandom), 8'($urandom), 16'($urandom),
                            16'($urandom_range(1, 64)));
      endcase
      stop_at = bytes_sent + ItemsPerSetting;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_frame(1'($urandom), pick_length(), FLAW_NONE, 1'b0, 8'h00);
        end else if (pick < 77) begin
          send_frame(1'($urandom), pick_length(), FLAW_CHECK, 1'b0, 8'h00);
        end else if (pick < 84) begin
          send_frame(1'($urandom), pick_length(), FLAW_TRUNCATE, 1'b0, 8'h00);
        end else if (pick < 92) begin
          send_frame(1'($urandom), pick_bad_length(), FLAW_NONE, 1'b0, 8'h00);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
        // hold the sender until the result stream has drained
        if ($urandom_range(0, 39) == 0) begin
          wait_for_results();
        end
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_SYNC_PLAIN;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    reset_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_register_extremes();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[host_command_frame_receiver_unit] OK");
    end else begin
      $display("[host_command_frame_receiver_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("[host_command_frame_receiver_unit] ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/hcfr_pkg.sv
hw/rtl/hcfr_if.sv
hw/rtl/hcfr_cfg_regs.sv
hw/rtl/hcfr_frame_fsm.sv
hw/rtl/hcfr_out_stage.sv
hw/rtl/host_command_frame_receiver_unit.sv
tb/sv/host_command_frame_receiver_unit_tb.sv
